[sv/cids_pkg.sv]
// Package for the chunked image DMA sequencer: result and opcode codes,
// register indexes, arithmetic unit operations and shared structs.
// No dependencies; every other file of the block but cids_in_if uses it.
package cids_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CHUNK  = 2'd0;
    localparam kind_t KIND_DONE   = 2'd1;
    localparam kind_t KIND_FAIL   = 2'd2;
    localparam kind_t KIND_REJECT = 2'd3;

    typedef logic [2:0] reg_index_t;
    localparam reg_index_t REG_FRAME_WIDTH     = 3'd0;
    localparam reg_index_t REG_FRAME_HEIGHT    = 3'd1;
    localparam reg_index_t REG_SAMPLE_DEPTH    = 3'd2;
    localparam reg_index_t REG_COMPONENT_COUNT = 3'd3;
    localparam reg_index_t REG_BUFFER_BASE     = 3'd4;

    localparam logic [4:0] DEPTH_8  = 5'd8;
    localparam logic [4:0] DEPTH_16 = 5'd16;

    typedef logic [1:0] alu_op_t;
    localparam alu_op_t ALU_ADD = 2'd0;
    localparam alu_op_t ALU_SUB = 2'd1;
    localparam alu_op_t ALU_MUL = 2'd2;

    typedef struct packed {
        logic [13:0] frame_width;
        logic [13:0] frame_height;
        logic [4:0]  sample_depth;
        logic [2:0]  component_count;
        logic [63:0] buffer_base;
    } cfg_t;

    typedef struct packed {
        logic opcode;
        logic done_flag;
        logic error_flag;
        logic halted_flag;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] chunk_address;
        logic [31:0] chunk_length;
        logic        last;
    } out_item_t;

    typedef struct packed {
        alu_op_t     op;
        logic [63:0] a;
        logic [63:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [63:0] result;
        logic        borrow;
    } alu_rsp_t;

endpackage

[sv/cids_cfg_if.sv]
// Configuration write channel of the chunked image DMA sequencer.
// Depends on cids_pkg for the register index type.
interface cids_cfg_if;
    logic                  valid;
    logic                  ready;
    cids_pkg::reg_index_t  index;
    logic [63:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/cids_in_if.sv]
// Event input channel of the chunked image DMA sequencer.
// Carries one start or status event per beat; no dependencies.
interface cids_in_if;
    logic valid;
    logic ready;
    logic opcode;
    logic done_flag;
    logic error_flag;
    logic halted_flag;

    modport source (output valid, output opcode, output done_flag,
                    output error_flag, output halted_flag, input ready);
    modport sink (input valid, input opcode, input done_flag,
                  input error_flag, input halted_flag, output ready);
endinterface

[sv/cids_out_if.sv]
// Result output channel of the chunked image DMA sequencer.
// Depends on cids_pkg for the result kind type.
interface cids_out_if;
    logic             valid;
    logic             ready;
    cids_pkg::kind_t  kind;
    logic [63:0]      chunk_address;
    logic [31:0]      chunk_length;
    logic             last;

    modport source (output valid, output kind, output chunk_address,
                    output chunk_length, output last, input ready);
    modport sink (input valid, input kind, input chunk_address,
                  input chunk_length, input last, output ready);
endinterface

[sv/cids_cfg_regs.sv]
// Configuration register file of the chunked image DMA sequencer.
// Depends on cids_pkg for the register indexes and the cfg_t struct.
module cids_cfg_regs
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    input  cids_pkg::reg_index_t  wr_index,
    input  logic [63:0]           wr_data,
    output cids_pkg::cfg_t        cfg
);

    cids_pkg::cfg_t cfg_reg;
    cids_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            unique case (wr_index)
                cids_pkg::REG_FRAME_WIDTH:     cfg_next.frame_width     = wr_data[13:0];
                cids_pkg::REG_FRAME_HEIGHT:    cfg_next.frame_height    = wr_data[13:0];
                cids_pkg::REG_SAMPLE_DEPTH:    cfg_next.sample_depth    = wr_data[4:0];
                cids_pkg::REG_COMPONENT_COUNT: cfg_next.component_count = wr_data[2:0];
                cids_pkg::REG_BUFFER_BASE:     cfg_next.buffer_base     = wr_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width     <= 14'd0;
            cfg_reg.frame_height    <= 14'd0;
            cfg_reg.sample_depth    <= cids_pkg::DEPTH_8;
            cfg_reg.component_count <= 3'd1;
            cfg_reg.buffer_base     <= 64'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/cids_alu.sv]
// Shared arithmetic unit of the chunked image DMA sequencer: a 64-bit add,
// a 64-bit subtract with borrow and a 32 by 16 bit multiply. Uses cids_pkg.
module cids_alu
(
    input  cids_pkg::alu_req_t req,
    output cids_pkg::alu_rsp_t rsp
);

    logic [64:0] sum;
    logic [47:0] product;

    assign product = req.a[31:0] * req.b[15:0];

    always_comb
    begin
        unique case (req.op)
            cids_pkg::ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
            cids_pkg::ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
            cids_pkg::ALU_MUL: sum = {17'd0, product};
            default:           sum = 65'd0;
        endcase
    end

    assign rsp.result = sum[63:0];
    assign rsp.borrow = sum[64];

endmodule

[sv/cids_seq.sv]
// Sequencer of the chunked image DMA sequencer: transfer state, the step
// sequence that drives the shared unit, and the output register.
// Depends on cids_pkg; drives one cids_alu.
module cids_seq
#(
    parameter logic [31:0] MAX_CHUNK_BYTES = 32'd8388607
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cids_pkg::cfg_t         cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cids_pkg::in_item_t     in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cids_pkg::out_item_t    out_item,
    output cids_pkg::alu_req_t     alu_req,
    input  cids_pkg::alu_rsp_t     alu_rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL_WH = 3'd1;
    localparam logic [2:0] S_MUL_F  = 3'd2;
    localparam logic [2:0] S_LIMIT  = 3'd3;
    localparam logic [2:0] S_ADD    = 3'd4;
    localparam logic [2:0] S_REM    = 3'd5;
    localparam logic [2:0] S_ADDR   = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [63:0]         acc_reg, acc_next;
    logic [31:0]         total_reg, total_next;
    logic [31:0]         done_reg, done_next;
    logic [31:0]         chunk_reg, chunk_next;
    logic                running_reg, running_next;
    logic                start_reg, start_next;
    cids_pkg::kind_t     pend_kind_reg, pend_kind_next;
    logic [63:0]         pend_addr_reg, pend_addr_next;
    logic [31:0]         pend_len_reg, pend_len_next;
    logic                out_valid_reg, out_valid_next;
    cids_pkg::out_item_t out_item_reg, out_item_next;

    logic                accept;
    logic                depth_ok;
    logic [3:0]          factor;
    logic [31:0]         limited;

    assign accept   = in_valid && in_ready;
    assign depth_ok = (cfg.sample_depth == cids_pkg::DEPTH_8)
                   || (cfg.sample_depth == cids_pkg::DEPTH_16);
    assign factor   = (cfg.sample_depth == cids_pkg::DEPTH_16)
                    ? {cfg.component_count, 1'b0} : {1'b0, cfg.component_count};
    assign limited  = alu_rsp.borrow ? acc_reg[31:0] : MAX_CHUNK_BYTES;

    always_comb
    begin
        alu_req.op = cids_pkg::ALU_ADD;
        alu_req.a  = 64'd0;
        alu_req.b  = 64'd0;
        unique case (state_reg)
            S_MUL_WH:
            begin
                alu_req.op = cids_pkg::ALU_MUL;
                alu_req.a  = {50'd0, cfg.frame_width};
                alu_req.b  = {50'd0, cfg.frame_height};
            end
            S_MUL_F:
            begin
                alu_req.op = cids_pkg::ALU_MUL;
                alu_req.a  = acc_reg;
                alu_req.b  = {60'd0, factor};
            end
            S_LIMIT:
            begin
                alu_req.op = cids_pkg::ALU_SUB;
                alu_req.a  = acc_reg;
                alu_req.b  = {32'd0, MAX_CHUNK_BYTES};
            end
            S_ADD:
            begin
                alu_req.op = cids_pkg::ALU_ADD;
                alu_req.a  = {32'd0, done_reg};
                alu_req.b  = {32'd0, chunk_reg};
            end
            S_REM:
            begin
                alu_req.op = cids_pkg::ALU_SUB;
                alu_req.a  = {32'd0, total_reg};
                alu_req.b  = {32'd0, done_reg};
            end
            S_ADDR:
            begin
                alu_req.op = cids_pkg::ALU_ADD;
                alu_req.a  = cfg.buffer_base;
                alu_req.b  = {32'd0, done_reg};
            end
            default:
            begin
                alu_req.op = cids_pkg::ALU_ADD;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        done_next      = done_reg;
        chunk_next     = chunk_reg;
        running_next   = running_reg;
        start_next     = start_reg;
        pend_kind_next = pend_kind_reg;
        pend_addr_next = pend_addr_reg;
        pend_len_next  = pend_len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_addr_next = 64'd0;
                    pend_len_next  = 32'd0;
                    if (in_item.opcode == cids_pkg::OP_START)
                    begin
                        start_next = 1'b1;
                        if (depth_ok)
                        begin
                            state_next = S_MUL_WH;
                        end
                        else
                        begin
                            pend_kind_next = cids_pkg::KIND_REJECT;
                            state_next     = S_EMIT;
                        end
                    end
                    else if (in_item.error_flag && in_item.halted_flag)
                    begin
                        running_next   = 1'b0;
                        pend_kind_next = cids_pkg::KIND_FAIL;
                        state_next     = S_EMIT;
                    end
                    else if (in_item.done_flag && running_reg)
                    begin
                        start_next = 1'b0;
                        state_next = S_ADD;
                    end
                end
            end
            S_MUL_WH:
            begin
                acc_next   = alu_rsp.result;
                state_next = S_MUL_F;
            end
            S_MUL_F:
            begin
                acc_next   = {32'd0, alu_rsp.result[31:0]};
                total_next = alu_rsp.result[31:0];
                done_next  = 32'd0;
                state_next = S_LIMIT;
            end
            S_LIMIT:
            begin
                chunk_next = limited;
                if (start_reg)
                begin
                    running_next   = 1'b1;
                    pend_kind_next = cids_pkg::KIND_CHUNK;
                    pend_addr_next = cfg.buffer_base;
                    pend_len_next  = limited;
                    state_next     = S_EMIT;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADD:
            begin
                done_next  = alu_rsp.result[31:0];
                state_next = S_REM;
            end
            S_REM:
            begin
                acc_next = {32'd0, alu_rsp.result[31:0]};
                if (!alu_rsp.borrow && (alu_rsp.result[31:0] != 32'd0))
                begin
                    state_next = S_LIMIT;
                end
                else
                begin
                    running_next   = 1'b0;
                    pend_kind_next = cids_pkg::KIND_DONE;
                    state_next     = S_EMIT;
                end
            end
            S_ADDR:
            begin
                pend_kind_next = cids_pkg::KIND_CHUNK;
                pend_addr_next = alu_rsp.result;
                pend_len_next  = chunk_reg;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.kind          = pend_kind_reg;
                    out_item_next.chunk_address = pend_addr_reg;
                    out_item_next.chunk_length  = pend_len_reg;
                    out_item_next.last          = 1'b1;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= 32'd0;
            done_reg      <= 32'd0;
            chunk_reg     <= 32'd0;
            running_reg   <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            done_reg      <= done_next;
            chunk_reg     <= chunk_next;
            running_reg   <= running_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        pend_kind_reg <= pend_kind_next;
        pend_addr_reg <= pend_addr_next;
        pend_len_reg  <= pend_len_next;
        out_item_reg  <= out_item_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[sv/chunked_image_dma_sequencer_core.sv]
// Top level of the chunked image DMA sequencer for one DMA channel.
// Depends on cids_pkg, the three channel interfaces, cids_cfg_regs,
// cids_seq and cids_alu.
//
// The cfg_ch channel writes the frame width, frame height, sample depth,
// component count and buffer base; it is always ready and must only be
// written while the block is idle. The in_ch channel takes one beat per
// start or status event. The out_ch channel gives at most one result beat
// per event, always marked last: a chunk to program, transfer done,
// transfer failed, or start rejected.
//
// A start passes through two multiply steps and one compare step on the
// shared arithmetic unit, then the write of the output register. A
// completion event that reports done takes an add and a subtract step; one
// that programs the next chunk takes add, subtract, compare and address add
// steps on the same unit. An error or reject goes straight to the output
// register write, and an event with nothing to report leaves the sequencer
// idle. in_ch.ready is high only while the sequencer is idle, so a new event
// is taken only once the result of the last one is in the output register.
//
// A finished result waits in the output register while a new event is
// accepted; the next result waits in the sequencer until that register is
// taken. Reset clears the transfer state and returns the registers to
// width 0, height 0, depth 8, one component and base 0.
module chunked_image_dma_sequencer_core
#(
    parameter logic [31:0] MAX_CHUNK_BYTES = 32'd8388607
)
(
    input  logic        clk,
    input  logic        rst_n,
    cids_cfg_if.sink    cfg_ch,
    cids_in_if.sink     in_ch,
    cids_out_if.source  out_ch
);

    cids_pkg::cfg_t      cfg;
    cids_pkg::in_item_t  in_item;
    cids_pkg::out_item_t out_item;
    cids_pkg::alu_req_t  alu_req;
    cids_pkg::alu_rsp_t  alu_rsp;

    assign cfg_ch.ready = 1'b1;

    assign in_item.opcode      = in_ch.opcode;
    assign in_item.done_flag   = in_ch.done_flag;
    assign in_item.error_flag  = in_ch.error_flag;
    assign in_item.halted_flag = in_ch.halted_flag;

    assign out_ch.kind          = out_item.kind;
    assign out_ch.chunk_address = out_item.chunk_address;
    assign out_ch.chunk_length  = out_item.chunk_length;
    assign out_ch.last          = out_item.last;

    cids_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg_ch.valid),
        .wr_index (cfg_ch.index),
        .wr_data  (cfg_ch.data),
        .cfg      (cfg)
    );

    cids_seq #(.MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)) u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_item   (in_item),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_item),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp)
    );

    cids_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

endmodule

[sv/cids_checker.sv]
// Port-level checker for the chunked image DMA sequencer and its bind.
// Depends on cids_pkg and on the top level chunked_image_dma_sequencer_core.
module cids_checker
#(
    parameter logic [31:0] MAX_CHUNK_BYTES = 32'd8388607
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             opcode,
    input  logic             out_valid,
    input  logic             out_ready,
    input  cids_pkg::kind_t  kind,
    input  logic [63:0]      chunk_address,
    input  logic [31:0]      chunk_length,
    input  logic             last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind)
        && $stable(chunk_address) && $stable(chunk_length))
        else $error("Result beat changed while stalled.");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == cids_pkg::OP_START) |=> !in_ready)
        else $error("Event input ready right after an accepted start beat.");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != cids_pkg::KIND_CHUNK)
        |-> (chunk_address == 64'd0) && (chunk_length == 32'd0))
        else $error("Non-chunk result carries an address or length.");

    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == cids_pkg::KIND_CHUNK) |-> chunk_length <= MAX_CHUNK_BYTES)
        else $error("Chunk length exceeds the maximum chunk size.");

    a_last_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> last)
        else $error("Result beat without last.");

endmodule

bind chunked_image_dma_sequencer_core cids_checker
    #(.MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)) u_cids_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .opcode        (in_ch.opcode),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .kind          (out_ch.kind),
    .chunk_address (out_ch.chunk_address),
    .chunk_length  (out_ch.chunk_length),
    .last          (out_ch.last)
);
